@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the checker files.
// Depends on a clk and an rst signal in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// check a property while out of reset
`define PHC_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("phc assertion failed");
// check a property on every edge, reset included
`define PHC_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) else $error("phc assertion failed");
`endif

@@ hw/rtl/phc_pkg.sv @@
// Shared types, constants and helpers of the packet header classifier.
// No dependencies.
package phc_pkg;

  localparam int COUNTER_BITS_DEF = 32;
  localparam int OFFSET_BITS_DEF  = 16;

  localparam logic [1:0] LINK_ETH  = 2'd0;
  localparam logic [1:0] LINK_NULL = 2'd1;

  localparam logic [1:0] MODE_NONE = 2'd0;
  localparam logic [1:0] MODE_IPV4 = 2'd1;
  localparam logic [1:0] MODE_IPV6 = 2'd2;

  localparam logic       REG_LINK_TYPE = 1'b0;
  localparam logic       REG_CAPTURE   = 1'b1;

  localparam logic [7:0] PROTO_ICMP   = 8'd1;
  localparam logic [7:0] PROTO_TCP    = 8'd6;
  localparam logic [7:0] PROTO_UDP    = 8'd17;
  localparam logic [7:0] PROTO_ICMPV6 = 8'd58;

  localparam logic [3:0] CLS_TCP    = 4'd0;
  localparam logic [3:0] CLS_TLS    = 4'd1;
  localparam logic [3:0] CLS_HTTP   = 4'd2;
  localparam logic [3:0] CLS_UDP    = 4'd3;
  localparam logic [3:0] CLS_DNS    = 4'd4;
  localparam logic [3:0] CLS_SSDP   = 4'd5;
  localparam logic [3:0] CLS_DHCP   = 4'd6;
  localparam logic [3:0] CLS_ICMP   = 4'd7;
  localparam logic [3:0] CLS_ICMPV6 = 4'd8;
  localparam logic [3:0] CLS_ARP    = 4'd9;
  localparam logic [3:0] CLS_IPV6   = 4'd10;
  localparam logic [3:0] CLS_ETH    = 4'd11;
  localparam logic [3:0] CLS_IPV4   = 4'd12;

  localparam logic [31:0] KW_HTTP = 32'h48545450;
  localparam logic [31:0] KW_GET  = 32'h47455420;
  localparam logic [39:0] KW_POST = 40'h504F535420;
  localparam logic [39:0] KW_USER = 40'h5553455220;
  localparam logic [39:0] KW_PASS = 40'h5041535320;

  typedef struct packed {
    logic [1:0]  mode;
    logic        is_arp;
    logic        is_eth_other;
    logic [7:0]  l4;
    logic [15:0] sp;
    logic [15:0] dp;
    logic [5:0]  ihb;
    logic [5:0]  thb;
    logic [15:0] len;
    logic [6:0]  l4_start;
    logic        kw_seen;
    logic        early_valid;
    logic [15:0] early_start;
    logic [15:0] wire_len;
  } frame_t;

  function automatic logic [1:0] ip_mode(input logic [1:0] lt, input logic [15:0] ek);
    logic [1:0] m;
    m = MODE_NONE;
    if (lt == LINK_ETH) begin
      if (ek == 16'h0800) m = MODE_IPV4;
      else if (ek == 16'h86DD) m = MODE_IPV6;
    end else if (lt == LINK_NULL) begin
      if (ek[15:8] == 8'd2 || ek[15:8] == 8'd24 || ek[7:0] == 8'h08) m = MODE_IPV4;
    end
    return m;
  endfunction

endpackage

@@ hw/rtl/phc_parse.sv @@
// Per-byte header capture and keyword scan; hands a frame snapshot on the last byte.
// Depends on phc_pkg.
module phc_parse #(
  parameter int OFFSET_BITS = phc_pkg::OFFSET_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [1:0]          link_type,
  input  logic                capture_enable,
  input  logic                in_fire,
  input  logic [7:0]          byte_value,
  input  logic                last_byte,
  input  logic [15:0]         wire_length,
  input  logic                snap_take,
  output logic                snap_valid,
  output phc_pkg::frame_t     snap
);

  localparam logic [OFFSET_BITS-1:0] OFF_MAX = '1;

  logic [OFFSET_BITS-1:0] byte_offset;
  logic [15:0] ether_kind, ip_length_field, port0, port1;
  logic [5:0]  ip_header_bytes, tcp_header_bytes;
  logic [7:0]  l4_protocol;
  logic [39:0] keyword_window;
  logic        keyword_seen, early_valid;
  logic [OFFSET_BITS-1:0] early_start;

  logic [15:0] ek_next, len_next, p0_next, p1_next;
  logic [5:0]  ihb_next, thb_next;
  logic [7:0]  l4_next;
  logic [39:0] win_next;
  logic        kw_next, ev_next;
  logic [OFFSET_BITS-1:0] es_next;
  logic [1:0]  mode;
  logic [16:0] oe, base, t, d, pend, start, thr;
  logic        take, hit4, hit5, hit;

  assign take = byte_offset != OFF_MAX;
  assign oe   = 17'(byte_offset);
  assign base = (link_type == phc_pkg::LINK_ETH) ? 17'd14 : 17'd4;

  always_comb begin
    ek_next = ether_kind;
    len_next = ip_length_field;
    ihb_next = ip_header_bytes;
    l4_next = l4_protocol;
    p0_next = port0;
    p1_next = port1;
    thb_next = tcp_header_bytes;
    win_next = keyword_window;
    kw_next = keyword_seen;
    ev_next = early_valid;
    es_next = early_start;
    hit4 = 1'b0;
    hit5 = 1'b0;
    hit = 1'b0;
    d = '0;
    start = '0;
    thr = '0;
    if (take) begin
      if (link_type == phc_pkg::LINK_ETH) begin
        if (oe == 17'd12) ek_next[15:8] = byte_value;
        if (oe == 17'd13) ek_next[7:0] = byte_value;
      end else if (link_type == phc_pkg::LINK_NULL) begin
        if (oe == 17'd0) ek_next[15:8] = byte_value;
        if (oe == 17'd2) ek_next[7:0] = byte_value;
      end
    end
    mode = phc_pkg::ip_mode(link_type, ek_next);
    if (take && mode == phc_pkg::MODE_IPV4) begin
      if (oe == base) ihb_next = {byte_value[3:0], 2'b00};
      if (oe == base + 17'd2) len_next[15:8] = byte_value;
      if (oe == base + 17'd3) len_next[7:0] = byte_value;
      if (oe == base + 17'd9) l4_next = byte_value;
    end else if (take && mode == phc_pkg::MODE_IPV6) begin
      if (oe == base + 17'd4) len_next[15:8] = byte_value;
      if (oe == base + 17'd5) len_next[7:0] = byte_value;
      if (oe == base + 17'd6) l4_next = byte_value;
    end
    t = (mode == phc_pkg::MODE_IPV6) ? base + 17'd40 : base + 17'(ihb_next);
    pend = (mode == phc_pkg::MODE_IPV6) ? base + 17'd40 + 17'(len_next)
                                         : base + 17'(len_next);
    if (take && mode != phc_pkg::MODE_NONE && oe >= t) begin
      d = oe - t;
      if (d == 17'd0) p0_next[15:8] = byte_value;
      if (d == 17'd1) p0_next[7:0] = byte_value;
      if (d == 17'd2) p1_next[15:8] = byte_value;
      if (d == 17'd3) p1_next[7:0] = byte_value;
      if (d == 17'd12) thb_next = {byte_value[7:4], 2'b00};
      win_next = {keyword_window[31:0], byte_value};
      hit4 = d >= 17'd3 && (win_next[31:0] == phc_pkg::KW_HTTP ||
                            win_next[31:0] == phc_pkg::KW_GET);
      hit5 = d >= 17'd4 && (win_next == phc_pkg::KW_POST ||
                            win_next == phc_pkg::KW_USER ||
                            win_next == phc_pkg::KW_PASS);
      hit = hit4 || hit5;
      start = hit5 ? oe - 17'd4 : oe - 17'd3;
      thr = t + 17'(thb_next);
      if (hit && oe < pend) begin
        if (d >= 17'd12) begin
          if (start >= thr) kw_next = 1'b1;
        end else begin
          ev_next = 1'b1;
          es_next = start[OFFSET_BITS-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_offset <= '0;
      ether_kind <= '0;
      ip_length_field <= '0;
      ip_header_bytes <= '0;
      l4_protocol <= '0;
      port0 <= '0;
      port1 <= '0;
      tcp_header_bytes <= '0;
      keyword_window <= '0;
      keyword_seen <= 1'b0;
      early_valid <= 1'b0;
      early_start <= '0;
      snap_valid <= 1'b0;
    end else begin
      if (in_fire && last_byte) snap_valid <= capture_enable;
      else if (snap_take) snap_valid <= 1'b0;
      if (in_fire) begin
        if (last_byte) begin
          byte_offset <= '0;
          ether_kind <= '0;
          ip_length_field <= '0;
          ip_header_bytes <= '0;
          l4_protocol <= '0;
          port0 <= '0;
          port1 <= '0;
          tcp_header_bytes <= '0;
          keyword_window <= '0;
          keyword_seen <= 1'b0;
          early_valid <= 1'b0;
          early_start <= '0;
        end else begin
          if (take) byte_offset <= byte_offset + 1'b1;
          ether_kind <= ek_next;
          ip_length_field <= len_next;
          ip_header_bytes <= ihb_next;
          l4_protocol <= l4_next;
          port0 <= p0_next;
          port1 <= p1_next;
          tcp_header_bytes <= thb_next;
          keyword_window <= win_next;
          keyword_seen <= kw_next;
          early_valid <= ev_next;
          early_start <= es_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && last_byte) begin
      snap.mode <= mode;
      snap.is_arp <= link_type == phc_pkg::LINK_ETH && ek_next == 16'h0806;
      snap.is_eth_other <= link_type == phc_pkg::LINK_ETH && mode == phc_pkg::MODE_NONE;
      snap.l4 <= l4_next;
      snap.sp <= p0_next;
      snap.dp <= p1_next;
      snap.ihb <= ihb_next;
      snap.thb <= thb_next;
      snap.len <= len_next;
      snap.l4_start <= t[6:0];
      snap.kw_seen <= kw_next;
      snap.early_valid <= ev_next;
      snap.early_start <= 16'(es_next);
      snap.wire_len <= wire_length;
    end
  end

endmodule

@@ hw/rtl/phc_classify.sv @@
// Frame classification, running counters and the result register.
// Depends on phc_pkg.
module phc_classify #(
  parameter int COUNTER_BITS = phc_pkg::COUNTER_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            snap_valid,
  input  phc_pkg::frame_t snap,
  output logic            snap_take,
  output logic            out_valid,
  input  logic            out_ready,
  output logic            stored,
  output logic [3:0]      protocol_class,
  output logic [15:0]     source_port,
  output logic [15:0]     destination_port,
  output logic            plaintext_flag,
  output logic [31:0]     tcp_count,
  output logic [31:0]     udp_count,
  output logic [31:0]     icmp_count,
  output logic [31:0]     arp_count,
  output logic [31:0]     misc_count,
  output logic [31:0]     packet_total,
  output logic [47:0]     byte_total
);

  logic [COUNTER_BITS-1:0] c_tcp, c_udp, c_icmp, c_arp, c_misc, c_total;
  logic [47:0] bytes;
  logic inc_tcp, inc_udp, inc_icmp, inc_arp, inc_misc, st, flag, l4_ports;
  logic [3:0] cls;
  logic ftp_tel, web, tls, scan, kw, paylen_pos;
  logic [16:0] thr;
  logic [17:0] hdr_sum;

  assign snap_take = snap_valid && (!out_valid || out_ready);

  always_comb begin
    inc_tcp = 1'b0;
    inc_udp = 1'b0;
    inc_icmp = 1'b0;
    inc_arp = 1'b0;
    inc_misc = 1'b0;
    st = 1'b0;
    flag = 1'b0;
    l4_ports = 1'b0;
    cls = phc_pkg::CLS_TCP;
    ftp_tel = snap.sp == 16'd21 || snap.dp == 16'd21 || snap.sp == 16'd23 ||
              snap.dp == 16'd23;
    web = snap.sp == 16'd80 || snap.dp == 16'd80;
    tls = snap.sp == 16'd443 || snap.dp == 16'd443;
    scan = ftp_tel || web;
    thr = 17'(snap.l4_start) + 17'(snap.thb);
    kw = snap.kw_seen || (snap.early_valid && 17'(snap.early_start) >= thr);
    hdr_sum = (snap.mode == phc_pkg::MODE_IPV6) ? 18'(snap.thb)
                                                 : 18'(snap.ihb) + 18'(snap.thb);
    paylen_pos = 18'(snap.len) > hdr_sum;
    if (snap.is_arp) begin
      inc_arp = 1'b1;
      st = 1'b1;
      cls = phc_pkg::CLS_ARP;
    end else if (snap.is_eth_other) begin
      inc_misc = 1'b1;
      st = 1'b1;
      cls = phc_pkg::CLS_ETH;
    end else if (snap.mode != phc_pkg::MODE_NONE) begin
      st = 1'b1;
      if (snap.l4 == phc_pkg::PROTO_TCP) begin
        inc_tcp = 1'b1;
        l4_ports = 1'b1;
        cls = tls ? phc_pkg::CLS_TLS : (web ? phc_pkg::CLS_HTTP : phc_pkg::CLS_TCP);
        flag = scan && paylen_pos && (ftp_tel || kw);
      end else if (snap.l4 == phc_pkg::PROTO_UDP) begin
        inc_udp = 1'b1;
        l4_ports = 1'b1;
        if (snap.sp == 16'd53 || snap.dp == 16'd53) cls = phc_pkg::CLS_DNS;
        else if (snap.sp == 16'd1900 || snap.dp == 16'd1900) cls = phc_pkg::CLS_SSDP;
        else if (snap.mode == phc_pkg::MODE_IPV4 &&
                 (snap.sp == 16'd67 || snap.sp == 16'd68 ||
                  snap.dp == 16'd67 || snap.dp == 16'd68)) cls = phc_pkg::CLS_DHCP;
        else cls = phc_pkg::CLS_UDP;
      end else if (snap.mode == phc_pkg::MODE_IPV6 && snap.l4 == phc_pkg::PROTO_ICMPV6) begin
        inc_icmp = 1'b1;
        cls = phc_pkg::CLS_ICMPV6;
      end else if (snap.mode == phc_pkg::MODE_IPV4 && snap.l4 == phc_pkg::PROTO_ICMP) begin
        inc_icmp = 1'b1;
        cls = phc_pkg::CLS_ICMP;
      end else begin
        inc_misc = 1'b1;
        cls = (snap.mode == phc_pkg::MODE_IPV6) ? phc_pkg::CLS_IPV6 : phc_pkg::CLS_IPV4;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_tcp <= '0;
      c_udp <= '0;
      c_icmp <= '0;
      c_arp <= '0;
      c_misc <= '0;
      c_total <= '0;
      bytes <= '0;
      out_valid <= 1'b0;
    end else begin
      if (snap_take) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      if (snap_take) begin
        bytes <= bytes + 48'(snap.wire_len);
        if (inc_tcp) c_tcp <= c_tcp + 1'b1;
        if (inc_udp) c_udp <= c_udp + 1'b1;
        if (inc_icmp) c_icmp <= c_icmp + 1'b1;
        if (inc_arp) c_arp <= c_arp + 1'b1;
        if (inc_misc) c_misc <= c_misc + 1'b1;
        if (st) c_total <= c_total + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (snap_take) begin
      stored <= st;
      protocol_class <= st ? cls : phc_pkg::CLS_TCP;
      source_port <= l4_ports ? snap.sp : 16'd0;
      destination_port <= l4_ports ? snap.dp : 16'd0;
      plaintext_flag <= flag;
    end
  end

  assign tcp_count = 32'(c_tcp);
  assign udp_count = 32'(c_udp);
  assign icmp_count = 32'(c_icmp);
  assign arp_count = 32'(c_arp);
  assign misc_count = 32'(c_misc);
  assign packet_total = 32'(c_total);
  assign byte_total = bytes;

endmodule

@@ hw/rtl/packet_header_classifier_unit.sv @@
// Packet header classifier: takes one frame byte per cycle (s_tvalid && s_tready) and
// reports one result per frame on the last byte while capture is on. The byte path is
// one register stage and classification a second: the last byte loads the frame snapshot
// and the result register then loads from it once any earlier result has been taken. With
// m_tready high a new byte is taken every cycle, including the first byte of the next
// frame. s_tready drops only while a finished frame waits behind a result that m_tready
// holds off. Counters and the byte total are cleared only by reset.
// Write link_type and capture_enable only while no frame is in flight.
module packet_header_classifier_unit #(
  parameter int COUNTER_BITS = phc_pkg::COUNTER_BITS_DEF,
  parameter int OFFSET_BITS  = phc_pkg::OFFSET_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [1:0]   cfg_data,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [23:0]  s_tdata,   // byte_value[7:0], wire_length[23:8]
  input  logic         s_tlast,   // last_byte
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [279:0] m_tdata,   // source_port, destination_port, plaintext_flag,
                                  // tcp, udp, icmp, arp, misc counts, packet_total,
                                  // byte_total[272:225], zero pad
  output logic [4:0]   m_tuser    // stored[0], protocol_class[4:1]
);

  logic [1:0] link_type;
  logic       capture_enable;
  logic       snap_valid, snap_take, in_fire;
  phc_pkg::frame_t snap;
  logic        stored, plaintext_flag;
  logic [3:0]  protocol_class;
  logic [15:0] source_port, destination_port;
  logic [31:0] tcp_count, udp_count, icmp_count, arp_count, misc_count, packet_total;
  logic [47:0] byte_total;

  always_ff @(posedge clk) begin
    if (rst) begin
      link_type <= phc_pkg::LINK_ETH;
      capture_enable <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        phc_pkg::REG_LINK_TYPE: link_type <= cfg_data;
        phc_pkg::REG_CAPTURE:   capture_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign s_tready = !snap_valid || snap_take;
  assign in_fire = s_tvalid && s_tready;

  phc_parse #(.OFFSET_BITS(OFFSET_BITS)) u_parse (
    .clk(clk), .rst(rst), .link_type(link_type), .capture_enable(capture_enable),
    .in_fire(in_fire), .byte_value(s_tdata[7:0]), .last_byte(s_tlast),
    .wire_length(s_tdata[23:8]), .snap_take(snap_take), .snap_valid(snap_valid),
    .snap(snap)
  );

  phc_classify #(.COUNTER_BITS(COUNTER_BITS)) u_classify (
    .clk(clk), .rst(rst), .snap_valid(snap_valid), .snap(snap), .snap_take(snap_take),
    .out_valid(m_tvalid), .out_ready(m_tready), .stored(stored),
    .protocol_class(protocol_class), .source_port(source_port),
    .destination_port(destination_port), .plaintext_flag(plaintext_flag),
    .tcp_count(tcp_count), .udp_count(udp_count), .icmp_count(icmp_count),
    .arp_count(arp_count), .misc_count(misc_count), .packet_total(packet_total),
    .byte_total(byte_total)
  );

  assign m_tdata = {7'd0, byte_total, packet_total, misc_count, arp_count, icmp_count,
                    udp_count, tcp_count, plaintext_flag, destination_port, source_port};
  assign m_tuser = {protocol_class, stored};

endmodule

@@ hw/rtl/phc_checker.sv @@
// Port-level checker for the packet header classifier, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"
module phc_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [279:0] m_tdata,
  input logic [4:0]   m_tuser
);

  `PHC_ASSERT_ALWAYS(a_reset_idle, rst |=> !m_tvalid)
  `PHC_ASSERT(a_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
  `PHC_ASSERT(a_drop_zero, m_tvalid && !m_tuser[0] |-> m_tuser == 5'd0 && m_tdata[32:0] == '0)
  `PHC_ASSERT(a_flag_tcp, m_tvalid && m_tdata[32] |-> m_tuser[0] && m_tuser[4:1] <= 4'd2)
  `PHC_ASSERT(a_stall_cause, s_tvalid && !s_tready |-> m_tvalid && !m_tready)

endmodule

bind packet_header_classifier_unit phc_checker u_phc_checker (.*);
